// ===== design/tli_pkg.sv =====
// ----------------------------------------------------------------------------
// tli_pkg: shared types and constants of the table linear interpolator
// widths, opcodes, register indexes, controller states and command structs
// ----------------------------------------------------------------------------
package tli_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int TABLE_BITS      = 8;
  localparam int FRAC_BITS       = 16;

  localparam int OP_W       = 2;
  localparam int IDX_W      = 8;
  localparam int VAL_W      = 8;
  localparam int AMT_W      = 16;
  localparam int OUT_W      = 16;
  localparam int XR_W       = 16;
  localparam int YR_W       = 16;
  localparam int N_W        = 8;
  localparam int SLOT_W     = 9;
  localparam int FX_W       = 32;
  localparam int SLOPE_W    = 33;
  localparam int FACTOR_W   = YR_W + TABLE_BITS;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_X_RANGE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_RANGE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES = 2'd2;

  localparam logic [XR_W-1:0] X_RANGE_RST = 16'd256;
  localparam logic [YR_W-1:0] Y_RANGE_RST = 16'd256;
  localparam logic [N_W-1:0]  ENTRIES_RST = 8'd16;
  localparam logic [OUT_W-1:0] OUT_MAX    = 16'hffff;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE   = 2'd0,
    OP_SET     = 2'd1,
    OP_ADVANCE = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    DIV_SPAN,
    DIV_POS,
    DIV_SLOPE
  } div_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SPAN,
    S_DECODE,
    S_POS_DIV,
    S_WALK,
    S_LOAD_RD1,
    S_LOAD_RD2,
    S_LOAD_CAP,
    S_LOAD_MUL,
    S_SLOPE_START,
    S_SLOPE_DIV,
    S_OUT_MUL,
    S_OUT_DONE
  } tli_state_t;

  typedef struct packed {
    logic     accept;
    logic     div_start;
    div_sel_t div_sel;
    logic     span_set;
    logic     table_write;
    logic     pos_set;
    logic     walk_init;
    logic     walk_step;
    logic     walk_finish;
    logic     rd_next;
    logic     cap_y1;
    logic     cap_y2;
    logic     load_mul;
    logic     slope_set;
    logic     out_mul;
    logic     result_load;
  } tli_cmd_t;

  typedef struct packed {
    logic    span_pending;
    logic    div_done;
    opcode_t op;
    logic    at_end;
    logic    pos_in_table;
    logic    walk_more;
    logic    walk_load;
    logic    out_busy;
  } tli_status_t;

endpackage

// ===== design/tli_if.sv =====
// ----------------------------------------------------------------------------
// tli_in_if / tli_out_if: request and result channels
// valid/ready handshake with the item fields as payload
// ----------------------------------------------------------------------------
interface tli_in_if;
  import tli_pkg::*;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [IDX_W-1:0] entry_index;
  logic [VAL_W-1:0] entry_value;
  logic [AMT_W-1:0] amount;
  modport source (output valid, opcode, entry_index, entry_value, amount, input ready);
  modport sink (input valid, opcode, entry_index, entry_value, amount, output ready);
endinterface

interface tli_out_if;
  import tli_pkg::*;
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] value;
  logic [OUT_W-1:0] position;
  logic             at_end;
  logic             range_error;
  modport source (output valid, value, position, at_end, range_error, input ready);
  modport sink (input valid, value, position, at_end, range_error, output ready);
endinterface

// ===== design/tli_divider.sv =====
// ----------------------------------------------------------------------------
// tli_divider: shared unsigned restoring divider
// one quotient bit per cycle, quotient and remainder valid with done
// ----------------------------------------------------------------------------
module tli_divider (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [tli_pkg::FX_W-1:0] dividend,
  input  logic [tli_pkg::FX_W-1:0] divisor,
  output logic                     done,
  output logic [tli_pkg::FX_W-1:0] quotient,
  output logic [tli_pkg::FX_W-1:0] remainder
);
  import tli_pkg::*;

  localparam int CNT_W = $clog2(FX_W + 1);

  logic [CNT_W-1:0] count;
  logic             busy;
  logic [FX_W-1:0]  dsr;
  logic [FX_W:0]    shifted;
  logic [FX_W:0]    trial;

  assign shifted = {remainder, quotient[FX_W-1]};
  assign trial   = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(FX_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= '0;
      quotient  <= dividend;
      dsr       <= divisor;
    end else if (busy) begin
      if (!trial[FX_W]) begin
        remainder <= trial[FX_W-1:0];
        quotient  <= {quotient[FX_W-2:0], 1'b1};
      end else begin
        remainder <= shifted[FX_W-1:0];
        quotient  <= {quotient[FX_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== design/tli_datapath.sv =====
// ----------------------------------------------------------------------------
// tli_datapath: registers, table memory, divider and result stage
// acts on commands from the controller, reports status back
// ----------------------------------------------------------------------------
module tli_datapath #(
  parameter int TABLE_DEPTH = tli_pkg::TABLE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  tli_pkg::tli_cmd_t              cmd,
  output tli_pkg::tli_status_t           status,
  input  logic                           cfg_we,
  input  logic [tli_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tli_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [tli_pkg::OP_W-1:0]       in_opcode,
  input  logic [tli_pkg::IDX_W-1:0]      in_entry_index,
  input  logic [tli_pkg::VAL_W-1:0]      in_entry_value,
  input  logic [tli_pkg::AMT_W-1:0]      in_amount,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tli_pkg::OUT_W-1:0]      out_value,
  output logic [tli_pkg::OUT_W-1:0]      out_position,
  output logic                           out_at_end,
  output logic                           out_range_error
);
  import tli_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  // configuration
  logic [XR_W-1:0] x_range;
  logic [YR_W-1:0] y_range;
  logic [N_W-1:0]  entries;
  logic            span_pending;

  // item
  opcode_t          op;
  logic [IDX_W-1:0] idx;
  logic [VAL_W-1:0] val;
  logic [AMT_W-1:0] amount;
  logic             err;

  // position state
  logic [SLOT_W-1:0]        slot;
  logic [FX_W-1:0]          offset;
  logic [FX_W-1:0]          base;
  logic signed [SLOPE_W-1:0] slope;
  logic [FX_W-1:0]          span;
  logic [FX_W-1:0]          es_prod;
  logic [FX_W:0]            walk_off;
  logic                     crossed;

  // slot load
  logic [TABLE_BITS-1:0] table_mem [TABLE_DEPTH];
  logic [TABLE_BITS-1:0] rdata;
  logic                  rd_oob;
  logic [SLOT_W-1:0]     rd_idx;
  logic [TABLE_BITS-1:0] y1;
  logic [TABLE_BITS-1:0] y2;
  logic [FX_W-1:0]       diff_mag;
  logic                  diff_neg;
  logic [FACTOR_W-1:0]   factor;
  logic [TABLE_BITS-1:0] ydiff;

  // result stage
  logic signed [49:0] prod_val;
  logic [40:0]        prod_pos;
  logic signed [50:0] sum_val;
  logic [41:0]        sum_pos;

  // divider
  logic [FX_W-1:0] div_dvd;
  logic [FX_W-1:0] div_dsr;
  logic            div_done;
  logic [FX_W-1:0] div_q;
  logic [FX_W-1:0] div_r;
  logic [FX_W-1:0] fx_amount;
  logic            pos_sat;
  logic            last_slot;

  assign fx_amount = {amount, 16'b0};
  assign factor    = {y_range, 8'b0};

  always_comb begin
    case (cmd.div_sel)
      DIV_SPAN: begin
        div_dvd = {x_range, 16'b0};
        div_dsr = {24'b0, entries};
      end
      DIV_POS: begin
        div_dvd = fx_amount;
        div_dsr = span;
      end
      default: begin
        div_dvd = diff_mag;
        div_dsr = {16'b0, span[31:16]};
      end
    endcase
  end

  tli_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_dvd),
    .divisor   (div_dsr),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // saturate slot at the end of the table, zero span maps everything there
  assign pos_sat   = (span == '0) || (div_q >= {24'b0, entries});
  assign last_slot = (slot + 1'b1) == {1'b0, entries};

  assign status.span_pending = span_pending;
  assign status.div_done     = div_done;
  assign status.op           = op;
  assign status.at_end       = slot >= {1'b0, entries};
  assign status.pos_in_table = !pos_sat;
  assign status.walk_more    = (walk_off >= {1'b0, span}) && (slot < {1'b0, entries});
  assign status.walk_load    = crossed && (slot < {1'b0, entries});
  assign status.out_busy     = out_valid && !out_ready;

  // configuration registers; span recompute is requested by x_range/entries writes
  always_ff @(posedge clk) begin
    if (rst) begin
      x_range      <= X_RANGE_RST;
      y_range      <= Y_RANGE_RST;
      entries      <= ENTRIES_RST;
      span_pending <= 1'b1;
    end else begin
      if (cmd.div_start && cmd.div_sel == DIV_SPAN) begin
        span_pending <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_X_RANGE: begin
            x_range      <= cfg_data[XR_W-1:0];
            span_pending <= 1'b1;
          end
          CFG_Y_RANGE: y_range <= cfg_data[YR_W-1:0];
          CFG_ENTRIES: begin
            entries      <= cfg_data[N_W-1:0];
            span_pending <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // position state
  always_ff @(posedge clk) begin
    if (rst) begin
      slot   <= '0;
      offset <= '0;
      base   <= '0;
      slope  <= '0;
      span   <= '0;
    end else begin
      if (cmd.span_set) begin
        span <= (entries == '0) ? '0 : div_q;
      end
      if (cmd.pos_set) begin
        slot   <= pos_sat ? {1'b0, entries} : div_q[SLOT_W-1:0];
        offset <= pos_sat ? fx_amount - es_prod : div_r;
      end
      if (cmd.walk_step) begin
        slot <= slot + 1'b1;
      end
      if (cmd.walk_finish) begin
        offset <= walk_off[FX_W] ? '1 : walk_off[FX_W-1:0];
      end
      if (cmd.load_mul) begin
        base <= {24'b0, y1} * {8'b0, factor};
      end
      if (cmd.slope_set) begin
        if (span[31:16] == '0) begin
          slope <= '0;
        end else if (diff_neg) begin
          slope <= -$signed({1'b0, div_q});
        end else begin
          slope <= $signed({1'b0, div_q});
        end
      end
    end
  end

  // item capture and working registers
  always_ff @(posedge clk) begin
    es_prod <= {24'b0, entries} * span;
    if (cmd.accept) begin
      op     <= opcode_t'(in_opcode);
      idx    <= in_entry_index;
      val    <= in_entry_value;
      amount <= in_amount;
      err    <= (span[31:16] == '0) ||
                ((opcode_t'(in_opcode) == OP_SET) && (in_amount > x_range));
    end
    if (cmd.walk_init) begin
      walk_off <= {1'b0, offset} + {1'b0, fx_amount};
      crossed  <= 1'b0;
    end
    if (cmd.walk_step) begin
      walk_off <= walk_off - {1'b0, span};
      crossed  <= 1'b1;
    end
    if (cmd.cap_y1) begin
      y1 <= rd_oob ? '0 : rdata;
    end
    if (cmd.cap_y2) begin
      y2 <= last_slot ? y1 : (rd_oob ? '0 : rdata);
    end
    if (cmd.load_mul) begin
      diff_mag <= {24'b0, ydiff} * {8'b0, factor};
      diff_neg <= y2 < y1;
    end
    if (cmd.out_mul) begin
      prod_val <= $signed({1'b0, offset[31:16]}) * slope;
      prod_pos <= {32'b0, slot} * {9'b0, span};
    end
  end

  assign ydiff = (y2 < y1) ? (y1 - y2) : (y2 - y1);

  // table memory, one write and one registered read
  assign rd_idx = cmd.rd_next ? slot + 1'b1 : slot;

  always_ff @(posedge clk) begin
    if (cmd.table_write && ({1'b0, idx} < 9'(TABLE_DEPTH))) begin
      table_mem[idx[AW-1:0]] <= val;
    end
  end

  always_ff @(posedge clk) begin
    rdata  <= table_mem[rd_idx[AW-1:0]];
    rd_oob <= rd_idx >= 9'(TABLE_DEPTH);
  end

  // result register
  assign sum_val = $signed({19'b0, base}) + $signed({prod_val[49], prod_val});
  assign sum_pos = {1'b0, prod_pos} + {10'b0, offset};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.result_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      if (sum_val[50]) begin
        out_value <= '0;
      end else if (|sum_val[49:32]) begin
        out_value <= OUT_MAX;
      end else begin
        out_value <= sum_val[31:16];
      end
      out_position    <= (|sum_pos[41:32]) ? OUT_MAX : sum_pos[31:16];
      out_at_end      <= status.at_end;
      out_range_error <= err;
    end
  end

endmodule

// ===== design/tli_controller.sv =====
// ----------------------------------------------------------------------------
// tli_controller: sequencer of the interpolator
// steps each request through decode and, as its opcode needs, division, slot walk and slot load
// ----------------------------------------------------------------------------
module tli_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tli_pkg::tli_status_t status,
  output tli_pkg::tli_cmd_t    cmd
);
  import tli_pkg::*;

  tli_state_t state;
  tli_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (status.span_pending) begin
          state_next = S_SPAN;
        end else if (in_valid) begin
          state_next = S_DECODE;
        end
      end
      S_SPAN: if (status.div_done) state_next = S_IDLE;
      S_DECODE: begin
        case (status.op)
          OP_SET: state_next = S_POS_DIV;
          OP_ADVANCE: state_next = status.at_end ? S_OUT_MUL : S_WALK;
          default: state_next = S_OUT_MUL;
        endcase
      end
      S_POS_DIV: begin
        if (status.div_done) begin
          state_next = status.pos_in_table ? S_LOAD_RD1 : S_OUT_MUL;
        end
      end
      S_WALK: begin
        if (!status.walk_more) begin
          state_next = status.walk_load ? S_LOAD_RD1 : S_OUT_MUL;
        end
      end
      S_LOAD_RD1: state_next = S_LOAD_RD2;
      S_LOAD_RD2: state_next = S_LOAD_CAP;
      S_LOAD_CAP: state_next = S_LOAD_MUL;
      S_LOAD_MUL: state_next = S_SLOPE_START;
      S_SLOPE_START: state_next = S_SLOPE_DIV;
      S_SLOPE_DIV: if (status.div_done) state_next = S_OUT_MUL;
      S_OUT_MUL: state_next = S_OUT_DONE;
      S_OUT_DONE: if (!status.out_busy) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.div_sel = DIV_SLOPE;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        if (status.span_pending) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_SPAN;
        end else begin
          in_ready   = 1'b1;
          cmd.accept = in_valid;
        end
      end
      S_SPAN: cmd.span_set = status.div_done;
      S_DECODE: begin
        case (status.op)
          OP_WRITE: cmd.table_write = 1'b1;
          OP_SET: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_POS;
          end
          OP_ADVANCE: cmd.walk_init = !status.at_end;
          default: ;
        endcase
      end
      S_POS_DIV: begin
        cmd.div_sel = DIV_POS;
        cmd.pos_set = status.div_done;
      end
      S_WALK: begin
        cmd.walk_step   = status.walk_more;
        cmd.walk_finish = !status.walk_more;
      end
      S_LOAD_RD1: cmd.rd_next = 1'b0;
      S_LOAD_RD2: begin
        cmd.rd_next = 1'b1;
        cmd.cap_y1  = 1'b1;
      end
      S_LOAD_CAP: cmd.cap_y2 = 1'b1;
      S_LOAD_MUL: cmd.load_mul = 1'b1;
      S_SLOPE_START: cmd.div_start = 1'b1;
      S_SLOPE_DIV: cmd.slope_set = status.div_done;
      S_OUT_MUL: cmd.out_mul = 1'b1;
      S_OUT_DONE: cmd.result_load = !status.out_busy;
      default: ;
    endcase
  end

endmodule

// ===== design/table_linear_interpolator.sv =====
// sequence from accepting edge to result valid: write entry, unused opcode, advance at end
//   go from decode to the result stage; set position adds a divider pass, advance a slot
//   walk; each adds a slot load with a second divider pass when a slot is loaded
// throughput: one request at a time, taken back in idle after the result is loaded and with
//   no slot width recompute pending; shared divider passes dominate set and slot load
// reset: synchronous, clears position state; the slot width is then computed before the
//   first request is taken; table contents stay undefined until written
// ----------------------------------------------------------------------------
// table_linear_interpolator: piecewise-linear interpolation over a byte table
// requests write the table, set or advance a 16.16 position; each returns
// the interpolated value, the position and two flags
// ----------------------------------------------------------------------------
module table_linear_interpolator #(
  parameter int TABLE_DEPTH = tli_pkg::TABLE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [tli_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tli_pkg::CFG_DATA_W-1:0] cfg_data,
  tli_in_if.sink                         in_ch,
  tli_out_if.source                      out_ch
);
  import tli_pkg::*;

  // command and status between sequencer and datapath
  tli_cmd_t    cmd;
  tli_status_t status;

  // sequencer: accepts a request only when idle and the slot width is current
  tli_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: config registers, table memory, divider, walk and result register
  tli_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_opcode       (in_ch.opcode),
    .in_entry_index  (in_ch.entry_index),
    .in_entry_value  (in_ch.entry_value),
    .in_amount       (in_ch.amount),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_value       (out_ch.value),
    .out_position    (out_ch.position),
    .out_at_end      (out_ch.at_end),
    .out_range_error (out_ch.range_error)
  );

endmodule

// ===== design/tli_checker.sv =====
// ----------------------------------------------------------------------------
// tli_checker: port-level checks of the interpolator
// request/result accounting and result hold under stall
// ----------------------------------------------------------------------------
module tli_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [tli_pkg::OUT_W-1:0]  out_value,
  input logic [tli_pkg::OUT_W-1:0]  out_position
);
  import tli_pkg::*;

  logic [1:0] outstanding;
  logic [1:0] outstanding_next;

  assign outstanding_next = outstanding + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding_next;
    end
  end

  // one request at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while another is in progress");

  // never more than one result waiting and one in progress
  a_accept_bound: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> (outstanding <= 2'd1))
    else $error("too many requests outstanding");

  // no result without a request
  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (outstanding != 2'd0))
    else $error("result without request");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_value) && $stable(out_position)))
    else $error("stalled result changed");

endmodule

bind table_linear_interpolator tli_checker u_chk (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_value    (out_ch.value),
  .out_position (out_ch.position)
);
